[src/msrd_pkg.sv]
// ----------------------------------------------------------------------------
// msrd_pkg
// Shared types, codes and constants of the modem serial receive deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package msrd_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] REG_PAYLOAD_LIMIT = 2'd0;
    localparam logic [1:0] REG_CLASS_A_TYPE  = 2'd1;
    localparam logic [1:0] REG_CLASS_B_TYPE  = 2'd2;

    localparam logic [15:0] PAYLOAD_LIMIT_RST = 16'd1536;
    localparam logic [15:0] CLASS_A_TYPE_RST  = 16'h88E1;
    localparam logic [15:0] CLASS_B_TYPE_RST  = 16'h86DD;

    // Frame header layout
    localparam logic [7:0]  START_BYTE     = 8'hAA;
    localparam logic [3:0]  HDR_OUTER_HI   = 4'd2;
    localparam logic [3:0]  HDR_OUTER_LO   = 4'd3;
    localparam logic [3:0]  HDR_START_FIRST = 4'd4;
    localparam logic [3:0]  HDR_START_LAST = 4'd7;
    localparam logic [3:0]  HDR_INNER_LO   = 4'd8;
    localparam logic [3:0]  HDR_INNER_HI   = 4'd9;
    localparam logic [3:0]  HDR_LAST       = 4'd11;
    localparam logic [16:0] LEN_OVERHEAD   = 17'd10;
    localparam logic [16:0] FOOTER_LEN     = 17'd2;

    // Ethertype position inside the payload
    localparam logic [15:0] TYPE_HI_IDX  = 16'd12;
    localparam logic [15:0] TYPE_LO_IDX  = 16'd13;
    localparam logic [15:0] KIND_MIN_LEN = 16'd14;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        KIND_OTHER   = 2'd0,
        KIND_CLASS_A = 2'd1,
        KIND_CLASS_B = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_SHORTENED = 2'd1,
        STAT_CUT       = 2'd2,
        STAT_BAD_HDR   = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       burst_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        carries_byte;
        logic        frame_first;
        logic        frame_last;
        logic [1:0]  frame_kind;
        logic [1:0]  frame_status;
        logic [15:0] delivered_length;
        logic [15:0] shortened_count;
    } t_out_item;

    // Frame kind from the ethertype; too short a frame has no type
    function automatic t_kind frame_kind_f(
        input logic [15:0] idx,
        input logic [15:0] type_word,
        input logic [15:0] type_a,
        input logic [15:0] type_b
    );
        t_kind k;
        if (idx < KIND_MIN_LEN) begin
            k = KIND_OTHER;
        end else if (type_word == type_a) begin
            k = KIND_CLASS_A;
        end else if (type_word == type_b) begin
            k = KIND_CLASS_B;
        end else begin
            k = KIND_OTHER;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

[src/msrd_front.sv]
// ----------------------------------------------------------------------------
// msrd_front
// Header parser and frame sequencer: takes one burst byte per cycle while
// i_accept is high and produces at most one result item for it.
// ----------------------------------------------------------------------------
`default_nettype none

module msrd_front
    import msrd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire t_in_item    i_in,
    output logic             o_emit,
    output t_out_item        o_item,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PAYLOAD,
        PH_SKIP,
        PH_DISCARD
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic [3:0]  r_hdr_idx,   n_hdr_idx;
    logic [15:0] r_outer,     n_outer;
    logic [15:0] r_inner,     n_inner;
    logic        r_start_ok,  n_start_ok;
    logic [15:0] r_pay_idx,   n_pay_idx;
    logic [15:0] r_type,      n_type;
    logic [16:0] r_skip,      n_skip;
    logic [15:0] r_short,     n_short;
    logic [15:0] r_target,    n_target;
    logic [15:0] r_limit;
    logic [15:0] r_type_a;
    logic [15:0] r_type_b;

    logic        sok;
    logic [16:0] skip_dec;
    logic        has_byte;
    logic        first;
    logic        last;
    t_status     status;
    logic [7:0]  b;
    logic        bend;

    assign o_cfg_ready = 1'b1;
    assign b    = i_in.rx_byte;
    assign bend = i_in.burst_end;

    always_comb begin
        n_phase    = r_phase;
        n_hdr_idx  = r_hdr_idx;
        n_outer    = r_outer;
        n_inner    = r_inner;
        n_start_ok = r_start_ok;
        n_pay_idx  = r_pay_idx;
        n_type     = r_type;
        n_skip     = r_skip;
        n_short    = r_short;
        n_target   = r_target;
        o_emit     = 1'b0;
        has_byte   = 1'b0;
        first      = 1'b0;
        last       = 1'b0;
        status     = STAT_OK;
        sok        = r_start_ok;
        skip_dec   = (r_skip != 17'd0) ? (r_skip - 17'd1) : 17'd0;

        if (i_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    sok = (r_hdr_idx == 4'd0) ? 1'b1 : r_start_ok;
                    if (r_hdr_idx == HDR_OUTER_HI) begin
                        n_outer = {b, r_outer[7:0]};
                    end else if (r_hdr_idx == HDR_OUTER_LO) begin
                        n_outer = {r_outer[15:8], b};
                    end else if (r_hdr_idx >= HDR_START_FIRST &&
                                 r_hdr_idx <= HDR_START_LAST) begin
                        if (b != START_BYTE) begin
                            sok = 1'b0;
                        end
                    end else if (r_hdr_idx == HDR_INNER_LO) begin
                        n_inner = {r_inner[15:8], b};
                    end else if (r_hdr_idx == HDR_INNER_HI) begin
                        n_inner = {b, r_inner[7:0]};
                    end
                    n_start_ok = sok;

                    if (r_hdr_idx < HDR_LAST) begin
                        if (bend) begin
                            n_hdr_idx  = 4'd0;
                            n_start_ok = 1'b1;
                        end else begin
                            n_hdr_idx = r_hdr_idx + 4'd1;
                        end
                    end else begin
                        n_pay_idx  = 16'd0;
                        n_type     = 16'd0;
                        n_hdr_idx  = 4'd0;
                        n_start_ok = 1'b1;
                        if (!(sok && ({1'b0, r_inner} + LEN_OVERHEAD == {1'b0, r_outer})))
                        begin
                            o_emit  = 1'b1;
                            last    = 1'b1;
                            status  = STAT_BAD_HDR;
                            n_phase = bend ? PH_HEADER : PH_DISCARD;
                        end else begin
                            if (r_inner > r_limit) begin
                                n_short  = r_short + 16'd1;
                                n_target = r_limit;
                            end else begin
                                n_target = r_inner;
                            end
                            n_skip = {1'b0, r_inner - n_target} + FOOTER_LEN;
                            if (bend) begin
                                o_emit  = 1'b1;
                                last    = 1'b1;
                                status  = STAT_CUT;
                                n_phase = PH_HEADER;
                            end else begin
                                n_phase = (n_target == 16'd0) ? PH_SKIP : PH_PAYLOAD;
                            end
                        end
                    end
                end

                PH_PAYLOAD: begin
                    o_emit   = 1'b1;
                    has_byte = 1'b1;
                    first    = (r_pay_idx == 16'd0);
                    if (r_pay_idx == TYPE_HI_IDX) begin
                        n_type = {b, r_type[7:0]};
                    end else if (r_pay_idx == TYPE_LO_IDX) begin
                        n_type = {r_type[15:8], b};
                    end
                    n_pay_idx = r_pay_idx + 16'd1;
                    if (bend) begin
                        last       = 1'b1;
                        status     = STAT_CUT;
                        n_phase    = PH_HEADER;
                        n_hdr_idx  = 4'd0;
                        n_start_ok = 1'b1;
                    end else if (n_pay_idx >= r_target) begin
                        n_phase = PH_SKIP;
                    end
                end

                PH_SKIP: begin
                    n_skip = skip_dec;
                    if (skip_dec == 17'd0) begin
                        o_emit     = 1'b1;
                        last       = 1'b1;
                        status     = (r_pay_idx < r_inner) ? STAT_SHORTENED : STAT_OK;
                        n_phase    = PH_HEADER;
                        n_hdr_idx  = 4'd0;
                        n_start_ok = 1'b1;
                    end else if (bend) begin
                        o_emit     = 1'b1;
                        last       = 1'b1;
                        status     = STAT_CUT;
                        n_phase    = PH_HEADER;
                        n_hdr_idx  = 4'd0;
                        n_start_ok = 1'b1;
                    end
                end

                PH_DISCARD: begin
                    // drop bytes until the burst ends
                    if (bend) begin
                        n_phase    = PH_HEADER;
                        n_hdr_idx  = 4'd0;
                        n_start_ok = 1'b1;
                    end
                end

                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
        end

        o_item.payload_byte     = has_byte ? b : 8'd0;
        o_item.carries_byte     = has_byte;
        o_item.frame_first      = first;
        o_item.frame_last       = last;
        o_item.frame_kind       = last ? frame_kind_f(n_pay_idx, n_type, r_type_a, r_type_b)
                                       : KIND_OTHER;
        o_item.frame_status     = last ? status : STAT_OK;
        o_item.delivered_length = last ? n_pay_idx : 16'd0;
        o_item.shortened_count  = n_short;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_idx  <= 4'd0;
            r_outer    <= 16'd0;
            r_inner    <= 16'd0;
            r_start_ok <= 1'b1;
            r_pay_idx  <= 16'd0;
            r_type     <= 16'd0;
            r_skip     <= 17'd0;
            r_short    <= 16'd0;
            r_target   <= 16'd0;
            r_limit    <= PAYLOAD_LIMIT_RST;
            r_type_a   <= CLASS_A_TYPE_RST;
            r_type_b   <= CLASS_B_TYPE_RST;
        end else begin
            r_phase    <= n_phase;
            r_hdr_idx  <= n_hdr_idx;
            r_outer    <= n_outer;
            r_inner    <= n_inner;
            r_start_ok <= n_start_ok;
            r_pay_idx  <= n_pay_idx;
            r_type     <= n_type;
            r_skip     <= n_skip;
            r_short    <= n_short;
            r_target   <= n_target;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_PAYLOAD_LIMIT: r_limit  <= i_cfg_data;
                    REG_CLASS_A_TYPE:  r_type_a <= i_cfg_data;
                    REG_CLASS_B_TYPE:  r_type_b <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[src/msrd_queue.sv]
// ----------------------------------------------------------------------------
// msrd_queue
// Result queue: holds finished items until the consumer pops them.
// ----------------------------------------------------------------------------
`default_nettype none

module msrd_queue
    import msrd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_wr,
    input  wire t_out_item i_data,
    input  wire logic      i_rd,
    output logic           o_full,
    output logic           o_empty,
    output t_out_item      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_out_item          r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        priority if (i_wr && !i_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_rd && !i_wr) begin
            n_count = r_count - CNT_W'(1);
        end else begin
            // hold the count when idle or on a simultaneous write and read
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[src/modem_spi_rx_deframer_top.sv]
// ----------------------------------------------------------------------------
// modem_spi_rx_deframer_top
// Receive-burst deframer: parses frame headers, streams payload bytes and
// reports per-frame status through a result queue.
// ----------------------------------------------------------------------------
// Throughput: one burst byte per cycle while the result queue is not full;
//   the header and counter logic of the front sequencer settles each byte.
// A result is queued as its byte is taken and shows once older results pop.
// full rises only when the result queue holds QUEUE_DEPTH unread items.
// Reset (synchronous, active low) empties the queue, returns the parser to
//   the header phase and loads the register defaults.
`default_nettype none

module modem_spi_rx_deframer_top
    import msrd_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire t_in_item    i_in,
    output logic             empty,
    input  wire logic        pop,
    output t_out_item        o_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic      accept;
    logic      emit;
    t_out_item item;

    assign accept = push && !full;

    msrd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in        (i_in),
        .o_emit      (emit),
        .o_item      (item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    msrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (emit),
        .i_data  (item),
        .i_rd    (pop && !empty),
        .o_full  (full),
        .o_empty (empty),
        .o_data  (o_out)
    );

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(full && empty))
        else $error("queue reports full and empty at once");

    a_first_has_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.frame_first) |-> o_out.carries_byte)
        else $error("frame start item without a payload byte");

    a_mid_frame_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out.frame_last) |->
            (o_out.frame_status == STAT_OK && o_out.delivered_length == 16'd0))
        else $error("status fields set on an item that does not end a frame");

    a_status_item_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out.carries_byte) |->
            (o_out.frame_last && o_out.payload_byte == 8'd0))
        else $error("status-only item not marked last or carries data");

endmodule

`default_nettype wire
